// File: hw/rtl/rqa_pkg.sv
// package for the red queue admission block: widths, codes, shared types
// used by every module of the block, depends on nothing

package rqa_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int Q_W         = 11;
  localparam int TIME_W      = 16;
  localparam int RAND_W      = 7;
  localparam int PAY_W       = 8;
  localparam int AVG_W       = 26;
  localparam int CNT_W       = 9;
  localparam int WGT_W       = 16;
  localparam int THR_W       = 11;
  localparam int PROB_W      = 16;
  localparam int LIM_W       = 8;
  localparam int RSN_W       = 3;
  localparam int FAC_W       = 17;
  localparam int MUL_A_W     = 26;
  localparam int MUL_B_W     = 17;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W     = 32;
  localparam int DIV_D_W     = 17;
  localparam int EXP_STEPS   = 16;
  localparam int REG_W       = 32;
  localparam int ADDR_W      = 5;
  localparam int IDX_W       = 3;

  localparam logic [FAC_W-1:0] ONE_Q16   = FAC_W'(65536);
  localparam logic [AVG_W-1:0] AVG_MAX   = {AVG_W{1'b1}};
  localparam logic [Q_W-1:0]   Q_SAT     = Q_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(255);

  localparam logic [WGT_W-1:0]  WEIGHT_RST = WGT_W'(197);
  localparam logic [THR_W-1:0]  MIN_RST    = THR_W'(5);
  localparam logic [THR_W-1:0]  MAX_RST    = THR_W'(15);
  localparam logic [PROB_W-1:0] PROB_RST   = PROB_W'(1311);
  localparam logic [LIM_W-1:0]  LIMIT_RST  = LIM_W'(50);

  localparam logic [IDX_W-1:0] REG_WEIGHT = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX    = 3'd2;
  localparam logic [IDX_W-1:0] REG_PROB   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

  typedef enum logic [RSN_W-1:0] {
    RSN_BELOW_MIN   = 3'd0,
    RSN_BAND_ACCEPT = 3'd1,
    RSN_RANDOM      = 3'd2,
    RSN_COUNT_LIMIT = 3'd3,
    RSN_ABOVE_MAX   = 3'd4
  } reason_t;

  typedef struct packed {
    logic [WGT_W-1:0]  weight;
    logic [THR_W-1:0]  min_thr;
    logic [THR_W-1:0]  max_thr;
    logic [PROB_W-1:0] max_prob;
    logic [LIM_W-1:0]  count_limit;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_EXP_P, CMD_EXP_B, CMD_DECAY, CMD_BUSY_F, CMD_BUSY_W,
    CMD_BUSY_SUM, CMD_CLASS, CMD_BAND_MUL, CMD_DIV_PB, CMD_PB_TAKE, CMD_CNT_MUL,
    CMD_D, CMD_DEC, CMD_DIV_PA, CMD_PA_TAKE, CMD_RAND, CMD_OUT
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ROUTE, ST_EXP_P, ST_EXP_B, ST_DECAY, ST_BUSY_F, ST_BUSY_W,
    ST_BUSY_SUM, ST_CLASS, ST_BAND_MUL, ST_DIV_PB, ST_WAIT_PB, ST_CNT_MUL,
    ST_D, ST_DEC, ST_DIV_PA, ST_WAIT_PA, ST_RAND, ST_OUT
  } state_t;

  typedef struct packed {
    logic q_zero;
    logic exp_last;
    logic in_band;
    logic div_done;
    logic need_pa;
    logic out_busy;
  } stat_t;

endpackage

// File: hw/rtl/rqa_div.sv
// restoring divider, one quotient bit per cycle
// depends on rqa_pkg for widths

module rqa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rqa_pkg::DIV_N_W-1:0] dividend,
  input  logic [rqa_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [rqa_pkg::DIV_N_W-1:0] quotient
);
  import rqa_pkg::*;

  localparam int STEP_W = $clog2(DIV_N_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_D_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_N_W-1:0] quo_r, quo_nxt;
  logic [DIV_D_W:0]   shifted;
  logic               ge;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_N_W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = ge ? DIV_D_W'(shifted - {1'b0, dvs_r}) : shifted[DIV_D_W-1:0];
      quo_nxt  = {quo_r[DIV_N_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/rqa_datapath.sv
// datapath: average update, band probability, drop decision, output register
// depends on rqa_pkg and rqa_div; driven by commands from rqa_ctrl

module rqa_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rqa_pkg::cfg_t              cfg,
  input  rqa_pkg::cmd_t              cmd,
  input  logic [rqa_pkg::Q_W-1:0]    in_queue_length,
  input  logic [rqa_pkg::TIME_W-1:0] in_now_time,
  input  logic [rqa_pkg::RAND_W-1:0] in_rand_percent,
  input  logic [rqa_pkg::PAY_W-1:0]  in_payload,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_drop,
  output logic [rqa_pkg::RSN_W-1:0]  out_decision_reason,
  output logic [rqa_pkg::PAY_W-1:0]  out_payload_out,
  output logic [rqa_pkg::AVG_W-1:0]  out_avg_length_q16,
  output rqa_pkg::stat_t             stat
);
  import rqa_pkg::*;

  localparam int LO_W  = THR_W + FRAC_BITS;
  localparam int SUM_W = AVG_W + 2;
  localparam int CMP_W = DIV_N_W + 7;
  localparam int D_W   = 26;

  logic [Q_W-1:0]           q_r;
  logic [RAND_W-1:0]        rand_r;
  logic [PAY_W-1:0]         pay_r;
  logic [AVG_W-1:0]         avg_r;
  logic signed [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0]        last_r;
  logic [TIME_W-1:0]        m_r;
  logic [3:0]               i_r;
  logic [FAC_W-1:0]         p_r, b_r;
  logic [MUL_P_W-1:0]       t_r, prod_r;
  logic [AVG_W-1:0]         diff_r;
  logic [PROB_W-1:0]        pb_r;
  logic signed [D_W-1:0]    d_r;
  logic [DIV_N_W-1:0]       pa_r;
  logic                     drop_r;
  reason_t                  reason_r;
  logic                     out_valid_r;
  logic                     out_drop_r;
  logic [RSN_W-1:0]         out_reason_r;
  logic [PAY_W-1:0]         out_pay_r;
  logic [AVG_W-1:0]         out_avg_r;

  logic [FAC_W-1:0]         fac;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [MUL_P_W-1:0]       mul;
  logic [LO_W-1:0]          lo, hi;
  logic                     above;
  logic                     limit_hit, d_nonpos;
  logic [SUM_W-1:0]         busy_sum;
  logic [AVG_W:0]           dec_avg;
  logic [CMP_W-1:0]         lhs, rhs;
  logic                     div_start;
  logic [DIV_N_W-1:0]       div_n;
  logic [DIV_D_W-1:0]       div_d;
  logic                     div_done;
  logic [DIV_N_W-1:0]       div_q;

  assign fac = ONE_Q16 - FAC_W'(cfg.weight);
  assign lo  = {cfg.min_thr, {FRAC_BITS{1'b0}}};
  assign hi  = {cfg.max_thr, {FRAC_BITS{1'b0}}};

  // one shared multiplier, operands chosen by the current command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      CMD_EXP_P:    begin mul_a = MUL_A_W'(p_r);   mul_b = b_r; end
      CMD_EXP_B:    begin mul_a = MUL_A_W'(b_r);   mul_b = b_r; end
      CMD_DECAY:    begin mul_a = avg_r;           mul_b = p_r; end
      CMD_BUSY_F:   begin mul_a = avg_r;           mul_b = fac; end
      CMD_BUSY_W:   begin mul_a = MUL_A_W'(q_r);   mul_b = MUL_B_W'(cfg.weight); end
      CMD_BAND_MUL: begin mul_a = diff_r;          mul_b = MUL_B_W'(cfg.max_prob); end
      CMD_CNT_MUL:  begin mul_a = MUL_A_W'(cnt_r[LIM_W-1:0]); mul_b = MUL_B_W'(pb_r); end
      default:      begin mul_a = '0;              mul_b = '0; end
    endcase
    mul = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  always_comb begin
    above     = hi <= LO_W'(avg_r);
    limit_hit = !cnt_r[CNT_W-1] && (cnt_r[LIM_W-1:0] == cfg.count_limit);
    d_nonpos  = d_r[D_W-1] || (d_r == '0);
    // (f*avg + w*(q<<16))>>16 equals (f*avg)>>16 + w*q, the low half being zero
    busy_sum  = SUM_W'(t_r[MUL_P_W-1:FRAC_BITS]) + SUM_W'(prod_r[AVG_W:0]);
    dec_avg   = mul[MUL_P_W-1:FRAC_BITS];
    lhs       = CMP_W'({rand_r, {FRAC_BITS{1'b0}}});
    rhs       = CMP_W'({pa_r, 6'b0}) + CMP_W'({pa_r, 5'b0}) + CMP_W'({pa_r, 2'b0});
  end

  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd)
      CMD_DIV_PB: begin
        div_start = 1'b1;
        div_n     = DIV_N_W'(prod_r[MUL_P_W-2:FRAC_BITS]);
        div_d     = DIV_D_W'(cfg.max_thr - cfg.min_thr);
      end
      CMD_DIV_PA: begin
        div_start = 1'b1;
        div_n     = {pb_r, {FRAC_BITS{1'b0}}};
        div_d     = d_r[DIV_D_W-1:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r  <= '0;
      cnt_r  <= '1;
      last_r <= '0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          if (in_queue_length == '0) last_r <= in_now_time;
        end
        CMD_DECAY: begin
          avg_r <= dec_avg[AVG_W] ? AVG_MAX : dec_avg[AVG_W-1:0];
        end
        CMD_BUSY_SUM: begin
          avg_r <= (busy_sum > SUM_W'(AVG_MAX)) ? AVG_MAX : busy_sum[AVG_W-1:0];
        end
        CMD_CLASS: begin
          if (stat.in_band) begin
            if (cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
          end else if (above) begin
            cnt_r <= '0;
          end else begin
            cnt_r <= '1;
          end
        end
        CMD_DEC: begin
          if (limit_hit || d_nonpos) cnt_r <= '0;
        end
        CMD_RAND: begin
          if (lhs < rhs) cnt_r <= '0;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        q_r    <= (in_queue_length > Q_SAT) ? Q_SAT : in_queue_length;
        rand_r <= in_rand_percent;
        pay_r  <= in_payload;
        m_r    <= in_now_time - last_r;
        i_r    <= '0;
        p_r    <= ONE_Q16;
        b_r    <= fac;
      end
      CMD_EXP_P: begin
        if (m_r[i_r]) p_r <= mul[FRAC_BITS+FAC_W-1:FRAC_BITS];
      end
      CMD_EXP_B: begin
        b_r <= mul[FRAC_BITS+FAC_W-1:FRAC_BITS];
        i_r <= i_r + 1'b1;
      end
      CMD_BUSY_F:   t_r    <= mul;
      CMD_BUSY_W:   prod_r <= mul;
      CMD_CLASS: begin
        diff_r <= AVG_W'(LO_W'(avg_r) - lo);
        if (above) begin
          drop_r   <= 1'b1;
          reason_r <= RSN_ABOVE_MAX;
        end else begin
          drop_r   <= 1'b0;
          reason_r <= RSN_BELOW_MIN;
        end
      end
      CMD_BAND_MUL: prod_r <= mul;
      CMD_PB_TAKE:  pb_r   <= div_q[PROB_W-1:0];
      CMD_CNT_MUL:  prod_r <= mul;
      CMD_D:        d_r    <= D_W'(ONE_Q16) - $signed({1'b0, prod_r[D_W-2:0]});
      CMD_DEC: begin
        if (limit_hit) begin
          drop_r   <= 1'b1;
          reason_r <= RSN_COUNT_LIMIT;
        end else if (d_nonpos) begin
          drop_r   <= 1'b1;
          reason_r <= RSN_RANDOM;
        end
      end
      CMD_PA_TAKE:  pa_r <= div_q;
      CMD_RAND: begin
        if (lhs < rhs) begin
          drop_r   <= 1'b1;
          reason_r <= RSN_RANDOM;
        end else begin
          drop_r   <= 1'b0;
          reason_r <= RSN_BAND_ACCEPT;
        end
      end
      default: begin
        pa_r <= pa_r;
      end
    endcase
  end

  // output register, parts the result side from the work in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd == CMD_OUT) begin
      out_drop_r   <= drop_r;
      out_reason_r <= reason_r;
      out_pay_r    <= pay_r;
      out_avg_r    <= avg_r;
    end
  end

  always_comb begin
    stat.q_zero   = (q_r == '0);
    stat.exp_last = (i_r == 4'(EXP_STEPS - 1));
    stat.in_band  = (lo <= LO_W'(avg_r)) && !above;
    stat.div_done = div_done;
    stat.need_pa  = !limit_hit && !d_nonpos;
    stat.out_busy = out_valid_r && out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_drop            = out_drop_r;
  assign out_decision_reason = out_reason_r;
  assign out_payload_out     = out_pay_r;
  assign out_avg_length_q16  = out_avg_r;

endmodule

// File: hw/rtl/rqa_ctrl.sv
// controller state machine: sequences the datapath through one request
// depends on rqa_pkg for state, command and status types

module rqa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rqa_pkg::stat_t stat,
  output logic           in_stall,
  output rqa_pkg::cmd_t  cmd
);
  import rqa_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_ROUTE;
      ST_ROUTE:    state_nxt = stat.q_zero ? ST_EXP_P : ST_BUSY_F;
      ST_EXP_P:    state_nxt = ST_EXP_B;
      ST_EXP_B:    state_nxt = stat.exp_last ? ST_DECAY : ST_EXP_P;
      ST_DECAY:    state_nxt = ST_CLASS;
      ST_BUSY_F:   state_nxt = ST_BUSY_W;
      ST_BUSY_W:   state_nxt = ST_BUSY_SUM;
      ST_BUSY_SUM: state_nxt = ST_CLASS;
      ST_CLASS:    state_nxt = stat.in_band ? ST_BAND_MUL : ST_OUT;
      ST_BAND_MUL: state_nxt = ST_DIV_PB;
      ST_DIV_PB:   state_nxt = ST_WAIT_PB;
      ST_WAIT_PB:  if (stat.div_done) state_nxt = ST_CNT_MUL;
      ST_CNT_MUL:  state_nxt = ST_D;
      ST_D:        state_nxt = ST_DEC;
      ST_DEC:      state_nxt = stat.need_pa ? ST_DIV_PA : ST_OUT;
      ST_DIV_PA:   state_nxt = ST_WAIT_PA;
      ST_WAIT_PA:  if (stat.div_done) state_nxt = ST_RAND;
      ST_RAND:     state_nxt = ST_OUT;
      ST_OUT:      if (!stat.out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = CMD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = CMD_LOAD;
      end
      ST_ROUTE:    cmd = CMD_NONE;
      ST_EXP_P:    cmd = CMD_EXP_P;
      ST_EXP_B:    cmd = CMD_EXP_B;
      ST_DECAY:    cmd = CMD_DECAY;
      ST_BUSY_F:   cmd = CMD_BUSY_F;
      ST_BUSY_W:   cmd = CMD_BUSY_W;
      ST_BUSY_SUM: cmd = CMD_BUSY_SUM;
      ST_CLASS:    cmd = CMD_CLASS;
      ST_BAND_MUL: cmd = CMD_BAND_MUL;
      ST_DIV_PB:   cmd = CMD_DIV_PB;
      ST_WAIT_PB:  if (stat.div_done) cmd = CMD_PB_TAKE;
      ST_CNT_MUL:  cmd = CMD_CNT_MUL;
      ST_D:        cmd = CMD_D;
      ST_DEC:      cmd = CMD_DEC;
      ST_DIV_PA:   cmd = CMD_DIV_PA;
      ST_WAIT_PA:  if (stat.div_done) cmd = CMD_PA_TAKE;
      ST_RAND:     cmd = CMD_RAND;
      ST_OUT:      if (!stat.out_busy) cmd = CMD_OUT;
      default:     cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/red_queue_admission_core.sv
// work per request: an empty queue runs 16 squaring steps of two multiplies each on one
// shared multiplier; inside the band a request runs up to two 32-step divisions on one
// shared restoring divider; one request at a time
// throughput: the next request is taken once the result sits in the output register
// reset: synchronous, active low; registers to defaults, average 0, count -1, idle mark 0
// top level: configuration registers and apb port, controller and datapath instances

module red_queue_admission_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rqa_pkg::Q_W-1:0]            in_queue_length,
  input  logic [rqa_pkg::TIME_W-1:0]         in_now_time,
  input  logic [rqa_pkg::RAND_W-1:0]         in_rand_percent,
  input  logic [rqa_pkg::PAY_W-1:0]          in_payload,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_drop,
  output logic [rqa_pkg::RSN_W-1:0]          out_decision_reason,
  output logic [rqa_pkg::PAY_W-1:0]          out_payload_out,
  output logic [rqa_pkg::AVG_W-1:0]          out_avg_length_q16,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rqa_pkg::ADDR_W-1:0]         paddr,
  input  logic [rqa_pkg::REG_W-1:0]          pwdata,
  output logic [rqa_pkg::REG_W-1:0]          prdata,
  output logic                               pready
);
  import rqa_pkg::*;

  cfg_t             cfg_r;
  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_idx;
  cmd_t             cmd;
  stat_t            stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weight      <= WEIGHT_RST;
      cfg_r.min_thr     <= MIN_RST;
      cfg_r.max_thr     <= MAX_RST;
      cfg_r.max_prob    <= PROB_RST;
      cfg_r.count_limit <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WEIGHT: cfg_r.weight      <= pwdata[WGT_W-1:0];
        REG_MIN:    cfg_r.min_thr     <= pwdata[THR_W-1:0];
        REG_MAX:    cfg_r.max_thr     <= pwdata[THR_W-1:0];
        REG_PROB:   cfg_r.max_prob    <= pwdata[PROB_W-1:0];
        REG_LIMIT:  cfg_r.count_limit <= pwdata[LIM_W-1:0];
        default:    cfg_r             <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WEIGHT: prdata = REG_W'(cfg_r.weight);
      REG_MIN:    prdata = REG_W'(cfg_r.min_thr);
      REG_MAX:    prdata = REG_W'(cfg_r.max_thr);
      REG_PROB:   prdata = REG_W'(cfg_r.max_prob);
      REG_LIMIT:  prdata = REG_W'(cfg_r.count_limit);
      default:    prdata = '0;
    endcase
  end

  rqa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rqa_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .in_queue_length     (in_queue_length),
    .in_now_time         (in_now_time),
    .in_rand_percent     (in_rand_percent),
    .in_payload          (in_payload),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_drop            (out_drop),
    .out_decision_reason (out_decision_reason),
    .out_payload_out     (out_payload_out),
    .out_avg_length_q16  (out_avg_length_q16),
    .stat                (stat)
  );

  // drop flag agrees with the reason code
  a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drop == ((out_decision_reason == RSN_RANDOM) ||
                                (out_decision_reason == RSN_COUNT_LIMIT) ||
                                (out_decision_reason == RSN_ABOVE_MAX))))
    else $error("drop flag does not match reason");

  // a taken request keeps the input side closed on the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while another is in progress");

  // a fresh result appears only after the input side has been closed
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule
